/* src/ean8_pkg.sv */
// ----------------------------------------------------------------------------
// ean8_pkg
// Shared constants, code tables and types for the EAN-8 module decoder.
// ----------------------------------------------------------------------------
package ean8_pkg;

  localparam int unsigned SymbolBits = 7;
  localparam int unsigned TableSize  = 10;

  // module positions within one row
  localparam logic [6:0] ModulesPerRow  = 7'd67;
  localparam logic [6:0] LeftDataFirst  = 7'd3;
  localparam logic [6:0] LeftDataEnd    = 7'd31;
  localparam logic [6:0] RightDataFirst = 7'd36;
  localparam logic [6:0] RightDataEnd   = 7'd64;

  // bit position of the last module of a digit group
  localparam logic [2:0] GroupLastBit = 3'd6;
  localparam logic [2:0] LastDigit    = 3'd7;

  typedef logic [SymbolBits-1:0] symbol_t;
  typedef logic [3:0]            digit_t;

  localparam symbol_t LeftCodes [TableSize] = '{
    7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
  };
  localparam symbol_t RightCodes [TableSize] = '{
    7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C, 7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
  };

  typedef struct packed {
    digit_t digit;
    logic   ok;
  } match_t;

endpackage

/* src/ean8_if.sv */
// ----------------------------------------------------------------------------
// ean8 channel interfaces
// Pixel input channel and decoded digit result channel, valid/ready.
// ----------------------------------------------------------------------------
interface ean8_in_if;
  logic valid;
  logic ready;
  logic pixel;
  logic start_of_row;

  modport source (output valid, output pixel, output start_of_row, input ready);
  modport sink   (input valid, input pixel, input start_of_row, output ready);
endinterface

interface ean8_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit;
  logic [2:0] digit_index;
  logic       code_ok;
  logic       last;

  modport source (output valid, output digit, output digit_index, output code_ok,
                  output last, input ready);
  modport sink   (input valid, input digit, input digit_index, input code_ok,
                  input last, output ready);
endinterface

/* src/ean8_code_match.sv */
// ----------------------------------------------------------------------------
// ean8_code_match
// Matches a 7-module symbol against the L-code or R-code table.
// ----------------------------------------------------------------------------
module ean8_code_match import ean8_pkg::*; (
  input  symbol_t symbol,
  input  logic    right_half,
  output match_t  result
);

  always_comb begin
    result = '0;
    // walk down so the lowest matching digit wins
    for (int j = TableSize - 1; j >= 0; j--) begin
      if (right_half ? (RightCodes[j] == symbol) : (LeftCodes[j] == symbol)) begin
        result.digit = digit_t'(j);
        result.ok    = 1'b1;
      end
    end
  end

endmodule

/* src/ean8_module_decoder.sv */
// ----------------------------------------------------------------------------
// ean8_module_decoder
// Samples one pixel per module of an EAN-8 row and emits the eight digits.
// ----------------------------------------------------------------------------
// output: a digit appears on the result channel in the cycle after
//   the transfer of the pixel that samples the seventh module of its group
// throughput: one pixel per cycle unless a stalled result is pending; the row
//   counters and the table match sit between state and result registers
// reset: idle until a pixel with start_of_row; side_margin 0, module_width 1
module ean8_module_decoder import ean8_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ean8_in_if.sink           in_if,
  ean8_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic RegSideMargin  = 1'b0;
  localparam logic RegModuleWidth = 1'b1;

  logic [7:0] side_margin_r, module_width_r;
  logic [7:0] margin_left_r, margin_left_nxt;
  logic [7:0] phase_count_r, phase_count_nxt;
  logic [6:0] module_index_r, module_index_nxt;
  symbol_t    symbol_bits_r, symbol_bits_nxt;
  logic [2:0] group_bit_r, group_bit_nxt;
  logic [2:0] digit_idx_r, digit_idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  digit_t     digit_r;
  logic [2:0] digit_index_r;
  logic       code_ok_r;
  logic       last_r;

  logic       in_xfer;
  logic       cfg_write;
  logic       emit;
  logic [7:0] s_margin, s_phase, width;
  logic [6:0] s_module;
  symbol_t    s_symbol, shifted;
  logic [2:0] s_group, s_digit;
  logic       in_data;
  match_t     match;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      RegSideMargin:  prdata = {24'd0, side_margin_r};
      RegModuleWidth: prdata = {24'd0, module_width_r};
      default:        prdata = '0;
    endcase
  end

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_xfer     = in_if.valid && in_if.ready;

  ean8_code_match u_match (
    .symbol     (shifted),
    .right_half (s_digit[2]),
    .result     (match)
  );

  always_comb begin
    // row start restarts all counters before this pixel is used
    s_margin = in_if.start_of_row ? side_margin_r : margin_left_r;
    s_phase  = in_if.start_of_row ? 8'd0          : phase_count_r;
    s_module = in_if.start_of_row ? 7'd0          : module_index_r;
    s_symbol = in_if.start_of_row ? '0            : symbol_bits_r;
    s_group  = in_if.start_of_row ? 3'd0          : group_bit_r;
    s_digit  = in_if.start_of_row ? 3'd0          : digit_idx_r;

    shifted = {s_symbol[SymbolBits-2:0], in_if.pixel};
    in_data = (s_module >= LeftDataFirst && s_module < LeftDataEnd) ||
              (s_module >= RightDataFirst && s_module < RightDataEnd);
    width   = (module_width_r == 8'd0) ? 8'd1 : module_width_r;

    margin_left_nxt  = s_margin;
    phase_count_nxt  = s_phase;
    module_index_nxt = s_module;
    symbol_bits_nxt  = s_symbol;
    group_bit_nxt    = s_group;
    digit_idx_nxt    = s_digit;
    emit             = 1'b0;

    if (s_module < ModulesPerRow) begin
      if (s_margin != 8'd0) begin
        margin_left_nxt = s_margin - 8'd1;
      end else begin
        if (s_phase == 8'd0 && in_data) begin
          symbol_bits_nxt = shifted;
          if (s_group == GroupLastBit) begin
            emit          = 1'b1;
            group_bit_nxt = 3'd0;
            digit_idx_nxt = s_digit + 3'd1;
          end else begin
            group_bit_nxt = s_group + 3'd1;
          end
        end
        // module ends once the phase count plus one reaches the current width
        if ({1'b0, s_phase} + 9'd1 >= {1'b0, width}) begin
          phase_count_nxt  = 8'd0;
          module_index_nxt = s_module + 7'd1;
        end else begin
          phase_count_nxt  = s_phase + 8'd1;
        end
      end
    end

    out_valid_nxt = in_xfer ? emit : (out_valid_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_margin_r  <= 8'd0;
      module_width_r <= 8'd1;
      margin_left_r  <= 8'd0;
      phase_count_r  <= 8'd0;
      module_index_r <= ModulesPerRow;
      symbol_bits_r  <= '0;
      group_bit_r    <= 3'd0;
      digit_idx_r    <= 3'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (paddr[2] == RegSideMargin) begin
          side_margin_r <= pwdata[7:0];
        end else begin
          module_width_r <= pwdata[7:0];
        end
      end
      if (in_xfer) begin
        margin_left_r  <= margin_left_nxt;
        phase_count_r  <= phase_count_nxt;
        module_index_r <= module_index_nxt;
        symbol_bits_r  <= symbol_bits_nxt;
        group_bit_r    <= group_bit_nxt;
        digit_idx_r    <= digit_idx_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      digit_r       <= match.digit;
      digit_index_r <= s_digit;
      code_ok_r     <= match.ok;
      last_r        <= (s_digit == LastDigit);
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.digit       = digit_r;
  assign out_if.digit_index = digit_index_r;
  assign out_if.code_ok     = code_ok_r;
  assign out_if.last        = last_r;

endmodule

/* bench/tb_ean8_module_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ean8_module_decoder
// Self-checking bench for the EAN-8 module decoder. Whole barcode rows are
// built from random digits and sent one pixel per transfer, with broken,
// truncated and noisy rows mixed in. A scoreboard tracks the row counters and
// predicts each decoded digit, which is checked against the result channel.
// ----------------------------------------------------------------------------
module tb_ean8_module_decoder;
  import ean8_pkg::*;

  localparam logic [2:0] AddrSideMargin  = 3'd0;
  localparam logic [2:0] AddrModuleWidth = 3'd4;
  localparam logic [2:0] SideGuard       = 3'b101;
  localparam logic [4:0] CentreGuard     = 5'b01010;
  localparam int MaxGap       = 17;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 4;
  localparam int TotalPixels  = 950;
  localparam int DrainLimit   = 5000;

  typedef struct packed {
    digit_t     digit;
    logic [2:0] idx;
    logic       ok;
    logic       last;
  } digit_res_t;

  typedef struct packed {
    logic pix;
    logic sor;
  } px_t;

  typedef symbol_t row_syms_t [8];

  // tracks the row position and holds the digits still to come out
  class ean8_digit_scoreboard;
    logic [7:0] side_margin;
    logic [7:0] module_width;
    logic [7:0] margin_left;
    logic [7:0] phase;
    logic [6:0] module_idx;
    symbol_t    sym;
    digit_res_t expected_q[$];
    int unsigned n_expected;
    int unsigned n_checked;
    int unsigned n_unmatched;

    function new();
      side_margin  = 8'd0;
      module_width = 8'd1;
      margin_left  = 8'd0;
      phase        = 8'd0;
      module_idx   = ModulesPerRow;
      sym          = '0;
      n_expected   = 0;
      n_checked    = 0;
      n_unmatched  = 0;
    endfunction

    function void set_reg(logic [2:0] addr, logic [7:0] val);
      case (addr)
        AddrSideMargin: side_margin = val;
        AddrModuleWidth: module_width = val;
        default: ;
      endcase
    endfunction

    function digit_res_t match_group(logic right_half, int pos);
      digit_res_t r;
      r.digit = '0;
      r.idx   = pos[2:0];
      r.ok    = 1'b0;
      r.last  = (pos[2:0] == LastDigit);
      for (int j = 0; j < TableSize; j++) begin
        if (!r.ok && (right_half ? RightCodes[j] : LeftCodes[j]) == sym) begin
          r.digit = digit_t'(j);
          r.ok    = 1'b1;
        end
      end
      return r;
    endfunction

    function void push_digit(digit_res_t r);
      expected_q.push_back(r);
      n_expected++;
      if (!r.ok) n_unmatched++;
    endfunction

    function void note_pixel(logic pix, logic sor);
      int m;
      int w;
      if (sor) begin
        margin_left = side_margin;
        phase       = 8'd0;
        module_idx  = 7'd0;
        sym         = '0;
      end
      if (module_idx >= ModulesPerRow) return;
      if (margin_left != 8'd0) begin
        margin_left--;
        return;
      end
      m = int'(module_idx);
      // only the first pixel of a module is sampled
      if (phase == 8'd0) begin
        if (m >= int'(LeftDataFirst) && m < int'(LeftDataEnd)) begin
          sym = {sym[SymbolBits-2:0], pix};
          if ((m - int'(LeftDataFirst)) % SymbolBits == GroupLastBit)
            push_digit(match_group(1'b0, (m - int'(LeftDataFirst)) / SymbolBits));
        end else if (m >= int'(RightDataFirst) && m < int'(RightDataEnd)) begin
          sym = {sym[SymbolBits-2:0], pix};
          if ((m - int'(RightDataFirst)) % SymbolBits == GroupLastBit)
            push_digit(match_group(1'b1, 4 + (m - int'(RightDataFirst)) / SymbolBits));
        end
      end
      w = (module_width == 8'd0) ? 1 : int'(module_width);
      if (int'(phase) + 1 >= w) begin
        phase = 8'd0;
        module_idx++;
      end else begin
        phase++;
      end
    endfunction

    function string check_digit(digit_res_t got);
      digit_res_t want;
      if (expected_q.size() == 0)
        return $sformatf("digit idx=%0d value=%0d with nothing outstanding",
                         got.idx, got.digit);
      want = expected_q.pop_front();
      n_checked++;
      if (got.digit !== want.digit || got.idx !== want.idx || got.ok !== want.ok ||
          got.last !== want.last)
        return $sformatf("value/idx/ok/last got %0d/%0d/%0d/%0d, want %0d/%0d/%0d/%0d",
                         got.digit, got.idx, got.ok, got.last,
                         want.digit, want.idx, want.ok, want.last);
      return "";
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ean8_in_if  in_ch ();
  ean8_out_if out_ch ();

  ean8_module_decoder u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ean8_digit_scoreboard sb;
  int unsigned errors;
  int unsigned rows_sent;
  int unsigned px_sent;
  bit          tx_idle;
  bit          rx_idle;
  bit          rx_hold_go;
  int          rx_wait;
  int          hold_left;
  px_t         row_px[$];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report(string msg);
    errors++;
    if (errors <= 60) $display("[%0t] ERROR %s", $time, msg);
  endtask

  // result side: random stall per digit, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
      hold_left = 0;
    end else begin
      if (rx_hold_go) begin
        hold_left = HoldCycles;
        rx_hold_go = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        rx_wait = rx_idle ? $urandom_range(0, MaxGap) : 0;
        out_ch.ready <= (rx_wait == 0);
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_ch.ready <= (rx_wait == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : digit_monitor
    digit_res_t got;
    string msg;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.digit = out_ch.digit;
      got.idx   = out_ch.digit_index;
      got.ok    = out_ch.code_ok;
      got.last  = out_ch.last;
      msg = sb.check_digit(got);
      if (msg != "") report(msg);
    end
  end

  task automatic send_pixel(px_t p);
    int gap;
    gap = tx_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pixel        <= p.pix;
    in_ch.start_of_row <= p.sor;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_pixel(p.pix, p.sor);
    px_sent++;
  endtask

  task automatic send_span(int first, int count);
    for (int i = first; i < first + count && i < row_px.size(); i++)
      send_pixel(row_px[i]);
  endtask

  // sender pauses until every digit is out and the pipeline has settled
  task automatic drain_digits();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_reg(addr, val);
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== {24'd0, val})
      report($sformatf("register at 0x%0h reads 0x%0h, written 0x%0h", addr, prdata, val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int margin, int width);
    drain_digits();
    cfg_write(AddrSideMargin, margin[7:0]);
    cfg_write(AddrModuleWidth, width[7:0]);
  endtask

  function automatic row_syms_t encode_digits(input int dig [8]);
    row_syms_t s;
    for (int k = 0; k < 8; k++) s[k] = (k < 4) ? LeftCodes[dig[k]] : RightCodes[dig[k]];
    return s;
  endfunction

  // margin pixels, then every module stretched to the current width;
  // pixels after the first of a module are mostly the same, sometimes random
  function automatic void build_row(input row_syms_t s, input int margin);
    logic [66:0] mods;
    px_t p;
    int w;
    mods = {SideGuard, s[0], s[1], s[2], s[3], CentreGuard, s[4], s[5], s[6], s[7],
            SideGuard};
    w = (sb.module_width == 8'd0) ? 1 : int'(sb.module_width);
    row_px.delete();
    for (int i = 0; i < margin; i++) begin
      p.pix = 1'($urandom_range(0, 1));
      p.sor = (i == 0);
      row_px.push_back(p);
    end
    for (int m = 0; m < 67; m++) begin
      for (int ph = 0; ph < w; ph++) begin
        p.pix = (ph == 0 || $urandom_range(0, 3) != 0) ? mods[66-m]
                                                        : 1'($urandom_range(0, 1));
        p.sor = (margin == 0 && m == 0 && ph == 0);
        row_px.push_back(p);
      end
    end
  endfunction

  function automatic row_syms_t random_symbols();
    int dig [8];
    row_syms_t s;
    for (int k = 0; k < 8; k++) dig[k] = $urandom_range(0, 9);
    s = encode_digits(dig);
    for (int k = 0; k < 8; k++)
      if ($urandom_range(0, 11) == 0) s[k] = s[k] ^ (7'd1 << $urandom_range(0, 6));
    return s;
  endfunction

  task automatic random_row();
    int kind;
    int n;
    px_t p;
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      build_row(random_symbols(), int'(sb.side_margin));
      // a truncated row is cut short by the next row start
      n = (kind < 70) ? row_px.size() : $urandom_range(1, row_px.size() - 1);
    end else begin
      n = $urandom_range(20, 120);
      row_px.delete();
      for (int i = 0; i < n; i++) begin
        p.pix = 1'($urandom_range(0, 1));
        p.sor = (i == 0) || ($urandom_range(0, 29) == 0);
        row_px.push_back(p);
      end
    end
    send_span(0, n);
    rows_sent++;
    if (kind < 70) begin
      // block is idle after the end guard, these pixels are dropped
      repeat ($urandom_range(0, 3)) begin
        p.pix = 1'($urandom_range(0, 1));
        p.sor = 1'b0;
        send_pixel(p);
      end
    end
    if ($urandom_range(0, 7) == 0) drain_digits();
  endtask

  initial begin
    row_syms_t s;
    px_t p;
    int sel;
    int margin;
    int width;

    errors             = 0;
    rows_sent          = 0;
    px_sent            = 0;
    tx_idle            = 1'b1;
    rx_idle            = 1'b1;
    rx_hold_go         = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.pixel        = 1'b0;
    in_ch.start_of_row = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // no row started yet: ignored
    repeat (5) begin
      p.pix = 1'($urandom_range(0, 1));
      p.sor = 1'b0;
      send_pixel(p);
    end

    // digits 0-3 on the left half, 4-7 on the right, long result hold-off
    rx_hold_go = 1'b1;
    build_row(encode_digits('{0, 1, 2, 3, 4, 5, 6, 7}), 0);
    send_span(0, row_px.size());

    // six codes that match nothing, two from the other half's table
    s = '{7'h00, 7'h7F, RightCodes[5], LeftCodes[3], LeftCodes[0], 7'h7F, 7'h00,
          RightCodes[9]};
    build_row(s, 0);
    send_span(0, row_px.size());

    // row restarted part way, then digits 8 and 9 on both halves
    build_row(random_symbols(), 0);
    send_span(0, 30);
    build_row(encode_digits('{8, 9, 0, 1, 9, 8, 2, 3}), 0);
    send_span(0, row_px.size());
    rows_sent += 4;

    // zero width behaves as one pixel per module
    configure(0, 0);
    build_row(random_symbols(), 0);
    send_span(0, row_px.size());

    // width shrunk while inside a module
    configure(5, 3);
    build_row(random_symbols(), 5);
    send_span(0, 5 + 3 * 20 + 2);
    configure(5, 1);
    build_row(random_symbols(), 0);
    send_span(20, row_px.size() - 20);

    // margin change mid-row only applies from the next row start
    build_row(random_symbols(), 5);
    send_span(0, 40);
    configure(255, 1);
    send_span(40, row_px.size() - 40);

    // widest margin, row cut short once the first digit is out
    build_row(random_symbols(), 255);
    send_span(0, 255 + 12);
    rows_sent += 5;

    while (px_sent < TotalPixels) begin
      sel = $urandom_range(0, 9);
      width = (sel < 5) ? 1 : (sel == 5) ? 0 : (sel == 6) ? 2 : (sel == 7) ? 3 :
              $urandom_range(4, 6);
      sel = $urandom_range(0, 11);
      margin = (sel < 4) ? 0 : (sel < 11) ? $urandom_range(1, 16) : 255;
      configure(margin, width);
      repeat ($urandom_range(2, 5)) begin
        if (px_sent < TotalPixels) random_row();
      end
    end

    in_ch.valid <= 1'b0;
    for (int i = 0; i < DrainLimit && sb.pending() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) report($sformatf("%0d digits never arrived", sb.pending()));

    $display("run: %0d pixels in %0d rows, %0d digits checked, %0d with no code match",
             px_sent, rows_sent, sb.n_checked, sb.n_unmatched);
    $display("widths 0 to 6, margins 0 to 255, mid-row register changes, result hold-off");
    if (errors == 0) begin
      $display("** ean8_module_decoder: PASSED **");
    end else begin
      $display("** ean8_module_decoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[%0t] timeout with %0d digits outstanding", $time, sb.pending());
    $display("** ean8_module_decoder: FAILED **");
    $finish;
  end

endmodule
